### rtl/assert_macros.svh
// Concurrent assertion macros used by the checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/hdlc_adf_pkg.sv
// Types and constants of the asynchronous HDLC deframer
package hdlc_adf_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [7:0]  ESC_BYTE       = 8'h7D;
    localparam logic [7:0]  ESC_FLAG       = 8'h5E;
    localparam logic [7:0]  ESC_ESC        = 8'h5D;
    localparam logic [15:0] EXP_LEN_RESET  = 16'd64;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FLAG   = 3'd1,
        PH_IN     = 3'd2,
        PH_ESC    = 3'd3,
        PH_IGNORE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_DATA     = 2'd0,
        EV_DONE     = 2'd1,
        EV_OVERFLOW = 2'd2,
        EV_BADESC   = 2'd3
    } t_event;

    typedef struct packed {
        logic        valid;
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
    } t_result;

endpackage

### rtl/hdlc_adf_in_reg.sv
// Input register stage of the deframer
module hdlc_adf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_rx_byte
);
    import hdlc_adf_pkg::*;

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_rx_byte;
    logic       w_load;

    assign o_in_ready = !r_valid || i_take;
    assign w_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds until the next load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_rx_byte = r_rx_byte;
endmodule

### rtl/hdlc_adf_decode.sv
// Frame state machine and byte unstuffing of the deframer
module hdlc_adf_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_kind,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_expected_length,
    output hdlc_adf_pkg::t_result o_result
);
    import hdlc_adf_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic        w_full;
    logic        w_esc_ok;
    logic [7:0]  w_unstuffed;

    assign w_full      = (r_count >= i_expected_length);
    assign w_esc_ok    = (i_rx_byte inside {ESC_FLAG, ESC_ESC});
    assign w_unstuffed = (i_rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_kind == KIND_RESTART) begin
            n_phase = PH_IDLE;
            n_count = '0;
        end else begin
            case (r_phase)
                PH_FLAG, PH_IN: begin
                    if (i_rx_byte == ESC_BYTE) begin
                        n_phase = PH_ESC;
                    end else if (i_rx_byte == FLAG_BYTE) begin
                        if (r_phase == PH_IN) begin
                            n_phase = PH_IDLE;
                            n_count = '0;
                        end
                    end else if (w_full) begin
                        n_phase = PH_IGNORE;
                        n_count = '0;
                    end else begin
                        n_phase = PH_IN;
                        n_count = r_count + 16'd1;
                    end
                end
                PH_ESC: begin
                    if (w_esc_ok && !w_full) begin
                        n_phase = PH_IN;
                        n_count = r_count + 16'd1;
                    end else begin
                        n_phase = PH_IGNORE;
                        n_count = '0;
                    end
                end
                PH_IGNORE: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == FLAG_BYTE) ? PH_FLAG : PH_IDLE;
                end
            endcase
        end
    end

    // Result
    always_comb begin
        o_result            = '0;
        o_result.event_res  = EV_DATA;
        if (i_kind == KIND_BYTE) begin
            case (r_phase)
                PH_FLAG, PH_IN: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        if (r_phase == PH_IN && r_count == i_expected_length) begin
                            o_result.valid      = 1'b1;
                            o_result.event_res  = EV_DONE;
                            o_result.byte_index = r_count;
                        end
                    end else if (i_rx_byte != ESC_BYTE) begin
                        o_result.valid      = 1'b1;
                        o_result.byte_index = r_count;
                        if (w_full) begin
                            o_result.event_res = EV_OVERFLOW;
                        end else begin
                            o_result.data_byte = i_rx_byte;
                        end
                    end
                end
                PH_ESC: begin
                    o_result.valid = 1'b1;
                    if (!w_esc_ok) begin
                        o_result.event_res = EV_BADESC;
                    end else if (w_full) begin
                        o_result.event_res  = EV_OVERFLOW;
                        o_result.byte_index = r_count;
                    end else begin
                        o_result.data_byte  = w_unstuffed;
                        o_result.byte_index = r_count;
                    end
                end
                default: begin
                    o_result.valid = 1'b0;
                end
            endcase
        end
    end
endmodule

### rtl/hdlc_adf_out_reg.sv
// Result register stage of the deframer
module hdlc_adf_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  hdlc_adf_pkg::t_result i_result,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_free,
    output logic [1:0]            o_event_res,
    output logic [7:0]            o_data_byte,
    output logic [15:0]           o_byte_index
);
    import hdlc_adf_pkg::*;

    logic        r_valid;
    t_event      r_event_res;
    logic [7:0]  r_data_byte;
    logic [15:0] r_byte_index;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event_res  <= i_result.event_res;
            r_data_byte  <= i_result.data_byte;
            r_byte_index <= i_result.byte_index;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_event_res  = r_event_res;
    assign o_data_byte  = r_data_byte;
    assign o_byte_index = r_byte_index;
endmodule

### rtl/hdlc_async_deframer_unit.sv
// Top level of the asynchronous HDLC byte-unstuffing deframer
// A result item passes the input register, then the result register, which captures it when its input item retires.
// Throughput: one input item per cycle unless a stalled output holds it; the frame state updates once per retired item.
// Input ready drops only while a result item waits on a stalled output.
// Reset (synchronous, active low): phase idle, count zero, both stages empty,
// expected length back to 64.
module hdlc_async_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import hdlc_adf_pkg::*;

    logic [15:0] r_exp_len;
    logic        w_s1_valid;
    logic        w_s1_kind;
    logic [7:0]  w_s1_byte;
    logic        w_take;
    logic        w_out_free;
    t_result     w_result;

    // Expected frame length register; write it only while no item is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= EXP_LEN_RESET;
        end else if (i_cfg_we) begin
            r_exp_len <= i_cfg_data;
        end
    end

    // Retire the held item when its result has room, or when it makes none
    assign w_take = w_s1_valid && (w_out_free || !w_result.valid);

    hdlc_adf_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_valid    (w_s1_valid),
        .o_kind     (w_s1_kind),
        .o_rx_byte  (w_s1_byte)
    );

    // Advance the frame state once per retired item
    hdlc_adf_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_take),
        .i_kind            (w_s1_kind),
        .i_rx_byte         (w_s1_byte),
        .i_expected_length (r_exp_len),
        .o_result          (w_result)
    );

    // Capture a result only when the item that made it retires
    hdlc_adf_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_take && w_result.valid),
        .i_result     (w_result),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_free       (w_out_free),
        .o_event_res  (o_event_res),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index)
    );
endmodule

### rtl/hdlc_adf_checker.sv
// Port-level checker of the deframer and its bind to the top level
`include "assert_macros.svh"

module hdlc_adf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_res,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_byte_index
);
    import hdlc_adf_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_event_res) && $stable(o_data_byte) && $stable(o_byte_index))
    `ASSERT_IMPLY(a_data_zero, i_clk, i_rst_n, o_out_valid && o_event_res != EV_DATA, o_data_byte == 8'd0)
    `ASSERT_IMPLY(a_badesc_idx, i_clk, i_rst_n, o_out_valid && o_event_res == EV_BADESC, o_byte_index == 16'd0)
endmodule

bind hdlc_async_deframer_unit hdlc_adf_checker u_hdlc_adf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_res  (o_event_res),
    .o_data_byte  (o_data_byte),
    .o_byte_index (o_byte_index)
);
